### sv/tansd_pkg.sv
// ----------------------------------------------------------------------------
// tansd_pkg
// Shared types, request and status codes, and helpers for the tANS
// table build and decode unit.
// ----------------------------------------------------------------------------
package tansd_pkg;

    // request codes
    localparam logic [1:0] REQ_SET_FREQ = 2'd0;
    localparam logic [1:0] REQ_START    = 2'd1;
    localparam logic [1:0] REQ_PUSH     = 2'd2;
    localparam logic [1:0] REQ_DECODE   = 2'd3;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DROPPED  = 3'd1;
    localparam logic [2:0] STAT_PADDED   = 3'd2;
    localparam logic [2:0] STAT_REJECTED = 3'd3;
    localparam logic [2:0] STAT_NO_TABLE = 3'd4;

    localparam int FREQ_W = 13;
    localparam int OCC_W  = 14;   // occurrence count reaches twice a frequency
    localparam int NB_W   = 5;    // bit count up to the largest table log
    localparam int SUM_W  = 21;   // 256 frequencies of 13 bits
    localparam int CNT_W  = 7;    // buffer fill 0..64
    localparam int BUF_W  = 64;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        sym_code;
        logic [FREQ_W-1:0] freq_count;
        logic              run_mode;
        logic [11:0]       start_state;
        logic [7:0]        data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       symbol_valid;
        logic [2:0] status;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic frq_acc;
        logic sym_inc;
        logic sym_clr;
        logic pos_clr;
        logic rem_ld;
        logic spread_wr;
        logic dt_wr;
        logic build_done;
        logic build_fail;
        logic dec_ex;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic table_ready;
        logic run_flag;
        logic sym_last;
        logic rem_zero;
        logic pos_last;
        logic sum_ok;
        logic out_busy;
    } ctl_sts_t;

    function automatic logic [NB_W-1:0] floor_log2(input logic [OCC_W-1:0] v);
        logic [NB_W-1:0] r;
        r = '0;
        for (int i = 1; i < OCC_W; i++) begin
            if (v[i]) r = NB_W'(i);
        end
        return r;
    endfunction

endpackage

### sv/tansd_ctrl.sv
// ----------------------------------------------------------------------------
// tansd_ctrl
// Sequencer for request acceptance, table build passes and decode steps.
// ----------------------------------------------------------------------------
module tansd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tansd_pkg::in_t      s_payload,
    input  logic                m_ready,
    input  tansd_pkg::ctl_sts_t sts,
    output tansd_pkg::ctl_cmd_t cmd
);
    import tansd_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b00000000001,
        ST_SUM_RD  = 11'b00000000010,
        ST_SUM_ACC = 11'b00000000100,
        ST_SUM_CHK = 11'b00000001000,
        ST_SP_RD   = 11'b00000010000,
        ST_SP_LD   = 11'b00000100000,
        ST_SP_FILL = 11'b00001000000,
        ST_DT_RD   = 11'b00010000000,
        ST_DT_OCC  = 11'b00100000000,
        ST_DT_WR   = 11'b01000000000,
        ST_DEC_EX  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE) && (!sts.out_busy || m_ready);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    if (s_payload.req_type == REQ_START && !s_payload.run_mode) begin
                        state_next = ST_SUM_RD;
                    end else if (s_payload.req_type == REQ_DECODE && sts.table_ready
                                 && !sts.run_flag) begin
                        state_next = ST_DEC_EX;
                    end
                end
            end
            ST_SUM_RD: state_next = ST_SUM_ACC;
            ST_SUM_ACC: begin
                cmd.frq_acc = 1'b1;
                if (sts.sym_last) begin
                    state_next = ST_SUM_CHK;
                end else begin
                    cmd.sym_inc = 1'b1;
                    state_next  = ST_SUM_RD;
                end
            end
            ST_SUM_CHK: begin
                if (sts.sum_ok) begin
                    cmd.sym_clr = 1'b1;
                    cmd.pos_clr = 1'b1;
                    state_next  = ST_SP_RD;
                end else begin
                    cmd.build_fail = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SP_RD: state_next = ST_SP_LD;
            ST_SP_LD: begin
                cmd.rem_ld = 1'b1;
                state_next = ST_SP_FILL;
            end
            ST_SP_FILL: begin
                if (sts.rem_zero) begin
                    if (sts.sym_last) begin
                        cmd.pos_clr = 1'b1;
                        state_next  = ST_DT_RD;
                    end else begin
                        cmd.sym_inc = 1'b1;
                        state_next  = ST_SP_RD;
                    end
                end else begin
                    cmd.spread_wr = 1'b1;
                end
            end
            ST_DT_RD:  state_next = ST_DT_OCC;
            ST_DT_OCC: state_next = ST_DT_WR;
            ST_DT_WR: begin
                cmd.dt_wr = 1'b1;
                if (sts.pos_last) begin
                    cmd.build_done = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_DT_RD;
                end
            end
            ST_DEC_EX: begin
                cmd.dec_ex = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/tansd_dpath.sv
// ----------------------------------------------------------------------------
// tansd_dpath
// Frequency, spread and decode table memories, bit buffer, decoder state
// and the result register.
// ----------------------------------------------------------------------------
module tansd_dpath #(
    parameter int TABLE_LOG = 12,
    parameter int ALPHABET  = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tansd_pkg::in_t      s_payload,
    input  tansd_pkg::ctl_cmd_t cmd,
    output tansd_pkg::ctl_sts_t sts,
    output logic                m_valid,
    input  logic                m_ready,
    output tansd_pkg::out_t     m_payload
);
    import tansd_pkg::*;

    localparam int TSIZE = 1 << TABLE_LOG;
    localparam int AW    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam logic [TABLE_LOG-1:0] STEP =
        TABLE_LOG'((TSIZE >> 1) + (TSIZE >> 3) + 3);

    // memories
    logic [FREQ_W-1:0]    freq_mem   [ALPHABET];
    logic                 freq_vld_reg [ALPHABET];
    logic [OCC_W-1:0]     occ_mem    [ALPHABET];
    logic [7:0]           spread_mem [TSIZE];
    logic [7:0]           dt_sym_mem [TSIZE];
    logic [NB_W-1:0]      dt_nb_mem  [TSIZE];
    logic [TABLE_LOG-1:0] dt_base_mem[TSIZE];

    logic [FREQ_W-1:0]    freq_rd_reg;
    logic                 freq_vrd_reg;
    logic [OCC_W-1:0]     occ_rd_reg;
    logic [7:0]           spread_rd_reg;
    logic [7:0]           dt_sym_rd_reg;
    logic [NB_W-1:0]      dt_nb_rd_reg;
    logic [TABLE_LOG-1:0] dt_base_rd_reg;

    // counters and decoder state
    logic [AW-1:0]        sym_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [FREQ_W-1:0]    rem_reg;
    logic [TABLE_LOG-1:0] pos_reg;
    logic [TABLE_LOG-1:0] dstate_reg;
    logic [BUF_W-1:0]     buf_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 ready_reg;
    logic                 run_reg;
    logic [7:0]           run_sym_reg;
    logic                 m_valid_reg;
    out_t                 res_reg;

    logic [FREQ_W-1:0]    freq_val;
    logic                 clr_freq;
    logic                 set_freq;
    logic [AW-1:0]        set_idx;

    // slot fill arithmetic
    logic [NB_W-1:0]      slot_nb;
    logic [31:0]          slot_shift;
    logic [TABLE_LOG-1:0] slot_base;

    // decode arithmetic
    logic [TABLE_LOG-1:0] dec_mask;
    logic [TABLE_LOG-1:0] dec_bits;
    logic [CNT_W-1:0]     dec_nb_w;

    out_t                 imm_res;
    logic                 imm_load;

    // result register load
    out_t                 res_next;
    logic                 res_set;

    assign freq_val = freq_vrd_reg ? freq_rd_reg : '0;
    assign clr_freq = cmd.build_done || cmd.build_fail
                      || (cmd.accept && s_payload.req_type == REQ_START && s_payload.run_mode);
    assign set_freq = cmd.accept && s_payload.req_type == REQ_SET_FREQ
                      && ({1'b0, s_payload.sym_code} < 9'(ALPHABET));
    assign set_idx  = s_payload.sym_code[AW-1:0];

    assign slot_nb    = NB_W'(TABLE_LOG) - floor_log2(occ_rd_reg);
    assign slot_shift = 32'(occ_rd_reg) << slot_nb;
    assign slot_base  = slot_shift[TABLE_LOG-1:0];

    assign dec_mask = ~({TABLE_LOG{1'b1}} << dt_nb_rd_reg);
    assign dec_bits = buf_reg[TABLE_LOG-1:0] & dec_mask;
    assign dec_nb_w = CNT_W'(dt_nb_rd_reg);

    assign sts.table_ready = ready_reg;
    assign sts.run_flag    = run_reg;
    assign sts.sym_last    = (32'(sym_reg) == ALPHABET - 1);
    assign sts.rem_zero    = (rem_reg == '0);
    assign sts.pos_last    = &pos_reg;
    assign sts.sum_ok      = (acc_reg == SUM_W'(TSIZE));
    assign sts.out_busy    = m_valid_reg;

    assign m_valid   = m_valid_reg;
    assign m_payload = res_reg;

    // results that are known at acceptance
    always_comb begin
        imm_res  = '0;
        imm_load = 1'b0;
        case (s_payload.req_type)
            REQ_SET_FREQ: imm_load = 1'b1;
            REQ_START:    imm_load = s_payload.run_mode;
            REQ_PUSH: begin
                imm_load = 1'b1;
                if (cnt_reg > CNT_W'(BUF_W - 8)) imm_res.status = STAT_DROPPED;
            end
            REQ_DECODE: begin
                if (!ready_reg) begin
                    imm_load       = 1'b1;
                    imm_res.status = STAT_NO_TABLE;
                end else if (run_reg) begin
                    imm_load             = 1'b1;
                    imm_res.out_symbol   = run_sym_reg;
                    imm_res.symbol_valid = 1'b1;
                end
            end
            default: imm_load = 1'b0;
        endcase
    end

    // next result transaction
    always_comb begin
        res_set  = 1'b0;
        res_next = imm_res;
        if (cmd.accept) res_set = imm_load;
        if (cmd.build_fail) begin
            res_set         = 1'b1;
            res_next        = '0;
            res_next.status = STAT_REJECTED;
        end
        if (cmd.build_done) begin
            res_set  = 1'b1;
            res_next = '0;
        end
        if (cmd.dec_ex) begin
            res_set               = 1'b1;
            res_next              = '0;
            res_next.out_symbol   = dt_sym_rd_reg;
            res_next.symbol_valid = 1'b1;
            res_next.status       = (cnt_reg < dec_nb_w) ? STAT_PADDED : STAT_OK;
        end
    end

    // frequency store valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ALPHABET; i++) freq_vld_reg[i] <= 1'b0;
        end else if (clr_freq) begin
            for (int i = 0; i < ALPHABET; i++) freq_vld_reg[i] <= 1'b0;
        end else if (set_freq) begin
            freq_vld_reg[set_idx] <= 1'b1;
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (set_freq) freq_mem[set_idx] <= s_payload.freq_count;
        freq_rd_reg  <= freq_mem[sym_reg];
        freq_vrd_reg <= freq_vld_reg[sym_reg];

        if (cmd.rem_ld) begin
            occ_mem[sym_reg] <= OCC_W'(freq_val);
        end else if (cmd.dt_wr) begin
            occ_mem[spread_rd_reg[AW-1:0]] <= occ_rd_reg + 1'b1;
        end
        occ_rd_reg <= occ_mem[spread_rd_reg[AW-1:0]];

        if (cmd.spread_wr) spread_mem[pos_reg] <= 8'(sym_reg);
        spread_rd_reg <= spread_mem[pos_reg];

        if (cmd.dt_wr) begin
            dt_sym_mem[pos_reg]  <= spread_rd_reg;
            dt_nb_mem[pos_reg]   <= slot_nb;
            dt_base_mem[pos_reg] <= slot_base;
        end
        dt_sym_rd_reg  <= dt_sym_mem[dstate_reg];
        dt_nb_rd_reg   <= dt_nb_mem[dstate_reg];
        dt_base_rd_reg <= dt_base_mem[dstate_reg];
    end

    // build counters
    always_ff @(posedge aclk) begin
        if (cmd.accept || cmd.sym_clr) begin
            sym_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (cmd.sym_inc) sym_reg <= sym_reg + 1'b1;
            if (cmd.frq_acc) acc_reg <= acc_reg + SUM_W'(freq_val);
        end
        if (cmd.rem_ld) begin
            rem_reg <= freq_val;
        end else if (cmd.spread_wr) begin
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.pos_clr) begin
            pos_reg <= '0;
        end else if (cmd.spread_wr) begin
            pos_reg <= pos_reg + STEP;
        end else if (cmd.dt_wr) begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // decoder state, bit buffer, flags and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg  <= '0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            ready_reg   <= 1'b0;
            run_reg     <= 1'b0;
            run_sym_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (res_set) begin
                m_valid_reg <= 1'b1;
                res_reg     <= res_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cmd.accept) begin
                case (s_payload.req_type)
                    REQ_START: begin
                        buf_reg    <= '0;
                        cnt_reg    <= '0;
                        dstate_reg <= TABLE_LOG'(s_payload.start_state);
                        run_reg    <= s_payload.run_mode;
                        ready_reg  <= s_payload.run_mode;
                        if (s_payload.run_mode) run_sym_reg <= s_payload.sym_code;
                    end
                    REQ_PUSH: begin
                        if (cnt_reg <= CNT_W'(BUF_W - 8)) begin
                            buf_reg <= buf_reg | (BUF_W'(s_payload.data_byte) << cnt_reg);
                            cnt_reg <= cnt_reg + CNT_W'(8);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (cmd.build_done) ready_reg <= 1'b1;

            if (cmd.dec_ex) begin
                buf_reg    <= buf_reg >> dt_nb_rd_reg;
                dstate_reg <= dt_base_rd_reg + dec_bits;
                if (cnt_reg < dec_nb_w) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg - dec_nb_w;
                end
            end
        end
    end

endmodule

### sv/tans_table_build_and_decode_unit.sv
// ----------------------------------------------------------------------------
// tans_table_build_and_decode_unit
// tANS decoder with decode table build from loaded symbol frequencies.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request per transaction: set frequency, build and
//   start, push byte, or decode one symbol. m_ channel returns exactly one
//   result transaction per request, in request order.
// sequencing:
//   set frequency, push byte, run-mode start and decodes in run mode or
//   without a table return their result in the cycle after acceptance.
//   a normal decode reads the decode table at acceptance, then updates the
//   state and bit buffer.
//   a build runs a frequency sum pass over every symbol, a spread pass
//   that loads each symbol and then writes its slots, and a fill pass
//   that reads each slot through the spread and occurrence memories and
//   writes its decode table entry. a rejected table ends after the sum pass.
//   one request is in flight at a time.
// reset: aresetn low clears the frequency store valid bits, the bit buffer,
//   decoder state and flags; table memories are written only by a build.
// stall: while a result transaction waits on m_ready the unit holds it and
//   takes a new request only in the cycle that result leaves.
// ----------------------------------------------------------------------------
module tans_table_build_and_decode_unit #(
    parameter int TABLE_LOG = 12,
    parameter int ALPHABET  = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tansd_pkg::in_t    s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output tansd_pkg::out_t   m_payload
);
    import tansd_pkg::*;

    // command and status between sequencer and datapath
    ctl_cmd_t cmd;
    ctl_sts_t sts;

    tansd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tansd_dpath #(
        .TABLE_LOG (TABLE_LOG),
        .ALPHABET  (ALPHABET)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

### test/tans_table_build_and_decode_unit_tb.sv
// ----------------------------------------------------------------------------
// tans_table_build_and_decode_unit_tb
// Self-checking bench: drives requests on the s_ channel, mirrors the table
// build and bitstream decode in a local predictor, and compares every m_
// transaction against the oldest predicted result.
// ----------------------------------------------------------------------------
module tans_table_build_and_decode_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tansd_pkg::*;

    localparam int TLOG = 12;
    localparam int TSZ = 1 << TLOG;
    localparam int STEP = (TSZ >> 1) + (TSZ >> 3) + 3;
    localparam int CYCLE_LIMIT = 4000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    tans_table_build_and_decode_unit #(.TABLE_LOG(TLOG), .ALPHABET(256)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #5 aclk = ~aclk;

    // predictor state
    int unsigned freqs[256];
    logic [7:0] tab_sym[TSZ];
    logic [4:0] tab_nb[TSZ];
    logic [11:0] tab_base[TSZ];
    logic [11:0] dec_state;
    logic [63:0] bitbuf;
    int unsigned bitcnt;
    bit have_table, run_on;
    logic [7:0] run_sym;

    out_t expected_q[$];
    int errors = 0;
    int unsigned cycles = 0;
    bit idle_on = 1'b1;
    bit hold_rx = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int flog2(input int unsigned v);
        int r;
        r = 0;
        while (v > 1) begin
            v >>= 1;
            r++;
        end
        return r;
    endfunction

    function automatic bit build_decode_table();
        int unsigned total, pos, x;
        logic [7:0] spread[TSZ];
        int unsigned occ[256];
        total = 0;
        pos = 0;
        foreach (freqs[s]) total += freqs[s];
        if (total != TSZ) return 1'b0;
        for (int s = 0; s < 256; s++) begin
            for (int k = 0; k < freqs[s]; k++) begin
                spread[pos] = s[7:0];
                pos = (pos + STEP) % TSZ;
            end
            occ[s] = freqs[s];
        end
        for (int p = 0; p < TSZ; p++) begin
            x = occ[spread[p]]++;
            tab_sym[p] = spread[p];
            tab_nb[p] = 5'(TLOG - flog2(x));
            tab_base[p] = 12'(((x << tab_nb[p]) - TSZ) % TSZ);
        end
        return 1'b1;
    endfunction

    // works out the result of one accepted request
    function automatic out_t predict_result(input in_t req);
        out_t r;
        logic [11:0] idx;
        int unsigned nb, bits;
        r = '0;
        r.status = STAT_OK;
        case (req.req_type)
            REQ_SET_FREQ: begin
                freqs[req.sym_code] = req.freq_count;
            end
            REQ_START: begin
                bitbuf = '0;
                bitcnt = 0;
                dec_state = req.start_state;
                if (req.run_mode) begin
                    run_on = 1'b1;
                    run_sym = req.sym_code;
                    have_table = 1'b1;
                end else begin
                    run_on = 1'b0;
                    have_table = build_decode_table();
                    if (!have_table) r.status = STAT_REJECTED;
                end
                foreach (freqs[s]) freqs[s] = 0;
            end
            REQ_PUSH: begin
                if (bitcnt + 8 > 64) r.status = STAT_DROPPED;
                else begin
                    bitbuf |= 64'(req.data_byte) << bitcnt;
                    bitcnt += 8;
                end
            end
            default: begin
                if (!have_table) r.status = STAT_NO_TABLE;
                else if (run_on) begin
                    r.out_symbol = run_sym;
                    r.symbol_valid = 1'b1;
                end else begin
                    idx = dec_state;
                    nb = tab_nb[idx];
                    bits = int'(bitbuf & ((64'd1 << nb) - 64'd1));
                    r.out_symbol = tab_sym[idx];
                    r.symbol_valid = 1'b1;
                    bitbuf >>= nb;
                    if (bitcnt < nb) begin
                        r.status = STAT_PADDED;
                        bitcnt = 0;
                    end else bitcnt -= nb;
                    dec_state = 12'(tab_base[idx] + bits);
                end
            end
        endcase
        return r;
    endfunction

    // sends one request, with an occasional random gap before it; valid stays high
    // into the next request unless a gap or a drain follows
    task automatic send_request(input in_t req);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_result(req));
        @(negedge aclk);
    endtask

    function automatic in_t make_req(input logic [1:0] kind);
        in_t r;
        r.req_type = kind;
        r.sym_code = 8'($urandom);
        r.freq_count = 13'($urandom);
        r.run_mode = 1'b0;
        r.start_state = 12'($urandom);
        r.data_byte = 8'($urandom);
        return r;
    endfunction

    task automatic set_freq(input int s, input int f);
        in_t r;
        r = make_req(REQ_SET_FREQ);
        r.sym_code = 8'(s);
        r.freq_count = 13'(f);
        send_request(r);
    endtask

    task automatic start_table(input bit run, input int s);
        in_t r;
        r = make_req(REQ_START);
        r.run_mode = run;
        r.sym_code = 8'(s);
        send_request(r);
    endtask

    // random legal distribution over a random alphabet
    task automatic load_random_freqs();
        int n, left, f, s;
        n = $urandom_range(1, 12);
        left = TSZ;
        s = $urandom_range(0, 255 - n);
        for (int i = 0; i < n; i++) begin
            f = (i == n - 1) ? left : $urandom_range(1, left - (n - 1 - i));
            if (i != n - 1 && $urandom_range(0, 1)) f = $urandom_range(1, 3);
            if (f > left - (n - 1 - i)) f = left - (n - 1 - i);
            set_freq(s + i, f);
            left -= f;
        end
    endtask

    task automatic push_and_decode(input int count);
        for (int i = 0; i < count; i++) begin
            if (bitcnt < 24 || $urandom_range(0, 5) == 0)
                send_request(make_req(REQ_PUSH));
            else send_request(make_req(REQ_DECODE));
        end
    endtask

    // sender stops offering until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_q.size() != 0) @(negedge aclk);
    endtask

    // decodes with no table, freq writes, rejections, extremes
    task automatic test_directed();
        in_t r;
        send_request(make_req(REQ_DECODE));
        set_freq(255, 8191);
        start_table(1'b0, 0);
        send_request(make_req(REQ_DECODE));
        set_freq(0, 4096);
        r = make_req(REQ_START);
        r.start_state = 12'hfff;
        send_request(r);
        send_request(make_req(REQ_DECODE));
        // two symbols, one rare, zero-padded decodes then pushes
        set_freq(0, 1);
        set_freq(255, 4095);
        start_table(1'b0, 0);
        for (int i = 0; i < 3; i++) send_request(make_req(REQ_DECODE));
        r = make_req(REQ_PUSH);
        r.data_byte = 8'hff;
        for (int i = 0; i < 9; i++) send_request(r);
        r.data_byte = 8'h00;
        send_request(r);
        send_request(make_req(REQ_DECODE));
        start_table(1'b1, 8'hff);
        send_request(make_req(REQ_DECODE));
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_rx = 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_rx = 1'b0;
            end
            push_and_decode(20);
        join
        wait_drained();
    endtask

    task automatic test_random_tables(input int rounds);
        for (int k = 0; k < rounds; k++) begin
            case ($urandom_range(0, 9))
                0: start_table(1'b1, $urandom_range(0, 255));
                1: begin
                    set_freq($urandom_range(0, 255), $urandom_range(0, 8191));
                    start_table(1'b0, 0);
                end
                default: begin
                    load_random_freqs();
                    start_table(1'b0, 0);
                end
            endcase
            push_and_decode($urandom_range(10, 60));
            if (k % 8 == 7) wait_drained();
        end
    endtask

    // checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected transaction", int'(m_payload), 0);
            end else begin
                want = expected_q.pop_front();
                if (m_payload.out_symbol !== want.out_symbol)
                    report("out_symbol", int'(m_payload.out_symbol),
                           int'(want.out_symbol));
                if (m_payload.symbol_valid !== want.symbol_valid)
                    report("symbol_valid", int'(m_payload.symbol_valid),
                           int'(want.symbol_valid));
                if (m_payload.status !== want.status)
                    report("status", int'(m_payload.status), int'(want.status));
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_rx) m_ready <= 1'b0;
            else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge aclk);
            end else m_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        foreach (freqs[s]) freqs[s] = 0;
        dec_state = '0;
        bitbuf = '0;
        bitcnt = 0;
        have_table = 1'b0;
        run_on = 1'b0;
        run_sym = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_tables(36);
        idle_on = 1'b0;
        test_random_tables(11);
        wait_drained();
        repeat (50) @(negedge aclk);
        if (errors == 0 && expected_q.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
